// ----- rtl/core/cwpi_pkg.sv -----
// Shared types and constants of the contention window PI controller.
package cwpi_pkg;

   // Fixed field widths.
   localparam int FIELD_W   = 16;
   localparam int GAIN_W    = 24;
   localparam int INTEG_W   = 32;
   localparam int WIN_W     = 11;
   localparam int EXP_W     = 4;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // The multiplier walks over every bit of the integral.
   localparam int MUL_BITS  = INTEG_W;

   localparam int MIN_CW    = 16;
   localparam int MAX_CW    = 1024;
   localparam logic [EXP_W-1:0] MIN_EXP = 4'd4;

   // Smallest window that rounds up to the next exponent (geometric midpoints).
   localparam int EXP_EDGE_N = 6;
   localparam logic [WIN_W-1:0] EXP_EDGE [EXP_EDGE_N] =
      '{11'd23, 11'd46, 11'd91, 11'd182, 11'd363, 11'd725};

   // Register indexes.
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_SAMPLES = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_PROP   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_INT    = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_TARGET_FAIL = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_INTEG_START = 3'd4;

   // Register reset values.
   localparam logic [FIELD_W-1:0] RST_MIN_SAMPLES = 16'd20;
   localparam logic [GAIN_W-1:0]  RST_GAIN_PROP   = 24'd53248;
   localparam logic [GAIN_W-1:0]  RST_GAIN_INT    = 24'd31322;
   localparam logic [FIELD_W-1:0] RST_TARGET_FAIL = 16'd13907;
   localparam logic [INTEG_W-1:0] RST_INTEG_START = 32'd137101;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_HCHK  = 9'b000000010,
      ST_HDIV  = 9'b000000100,
      ST_OCHK  = 9'b000001000,
      ST_ODIV  = 9'b000010000,
      ST_MUL   = 9'b000100000,
      ST_ROUND = 9'b001000000,
      ST_DONE  = 9'b010000000,
      ST_SPARE = 9'b100000000
   } state_type;

endpackage

// ----- rtl/core/contention_window_pi_controller.sv -----
// Top level of the contention window PI controller.
//
// One request transaction is one tick of frame counts. The counts are added into saturating
// accumulators in the cycle of acceptance; a tick whose overheard counts do not reach the
// sample threshold goes back to idle from the first check state. Each retry ratio comes from
// a restoring divider that forms one quotient bit per cycle, and the PI sum comes from a
// shift-add multiplier that takes one bit of the error and of the integral per cycle. A tick
// whose own counts fall short of the threshold forms only the overheard ratio and gives no
// response. The final step waits until the previous response has been taken before it
// registers the new window. A new request is taken only when the sequencer is idle, while an
// earlier response may still be waiting.
module contention_window_pi_controller #(
   parameter int COUNT_WIDTH    = 16,
   parameter int PROB_FRAC_BITS = 16,
   parameter int GAIN_FRAC_BITS = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [cwpi_pkg::FIELD_W-1:0]         req_heard_retry,
   input  logic [cwpi_pkg::FIELD_W-1:0]         req_heard_clean,
   input  logic [cwpi_pkg::FIELD_W-1:0]         req_own_retry,
   input  logic [cwpi_pkg::FIELD_W-1:0]         req_own_tx,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [cwpi_pkg::WIN_W-1:0]           rsp_cw_window,
   output logic [cwpi_pkg::EXP_W-1:0]           rsp_cw_exponent,
   output logic [cwpi_pkg::FIELD_W-1:0]         rsp_heard_prob,
   input  logic                                 csr_wr_en,
   input  logic [cwpi_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [cwpi_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import cwpi_pkg::*;

   localparam int C      = COUNT_WIDTH;
   localparam int P      = PROB_FRAC_BITS;
   localparam int SUM_W  = ((C > FIELD_W) ? C : FIELD_W) + 1;
   localparam int DEN_W  = C + 1;
   localparam int CMP_W  = (DEN_W > FIELD_W) ? DEN_W : FIELD_W;
   localparam int D_W    = C + P + 1;
   localparam int E_W    = (((P + 1) > FIELD_W) ? (P + 1) : FIELD_W) + 2;
   localparam int TERM_W = GAIN_W + 2;
   localparam int ACC_W  = GAIN_W + INTEG_W + 2;
   localparam int SHIFT  = GAIN_FRAC_BITS + PROB_FRAC_BITS;
   localparam int CNT_W  = $clog2(MUL_BITS);
   localparam logic [C-1:0]     COUNT_MAX = '1;
   localparam logic [ACC_W-1:0] HALF      = ACC_W'(1) << (SHIFT - 1);

   state_type            state_ff, state_in;
   logic [FIELD_W-1:0]   min_samples_ff;
   logic [GAIN_W-1:0]    gain_prop_ff, gain_int_ff;
   logic [FIELD_W-1:0]   target_fail_ff;
   logic [INTEG_W-1:0]   integral_ff, integral_in;
   logic [C-1:0]         hr_acc_ff, hr_acc_in, hc_acc_ff, hc_acc_in;
   logic [C-1:0]         or_acc_ff, or_acc_in, ot_acc_ff, ot_acc_in;
   logic [DEN_W-1:0]     rem_ff, rem_in, den_ff, den_in;
   logic [P:0]           dlo_ff, dlo_in;
   logic                 den_zero_ff, den_zero_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [P-1:0]         heard_ff, heard_in;
   logic [E_W-1:0]       err_ff, err_in;
   logic [MUL_BITS-1:0]  mpe_ff, mpe_in, mpi_ff, mpi_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WIN_W-1:0]     rsp_window_ff, rsp_window_in;
   logic [EXP_W-1:0]     rsp_exp_ff, rsp_exp_in;
   logic [FIELD_W-1:0]   rsp_prob_ff, rsp_prob_in;

   logic                 req_take, rsp_free;
   logic [DEN_W-1:0]     hsum, osum, ld_num, ld_den;
   logic                 h_enough, o_enough;
   logic [D_W-1:0]       d_full;
   logic [DEN_W:0]       trial;
   logic                 ge;
   logic [P:0]           q_raw;
   logic [P-1:0]         q_sat;
   logic [E_W-1:0]       err_c;
   logic [TERM_W-1:0]    term;
   logic [ACC_W-1:0]     acc_shl;
   logic signed [ACC_W-1:0] win_s;
   logic [WIN_W-1:0]     win_c;
   logic [EXP_W-1:0]     exp_c;
   logic [INTEG_W:0]     ni;
   logic [31:0]          prob_wide;

   function automatic logic [C-1:0] sat_add(input logic [C-1:0] a,
                                            input logic [FIELD_W-1:0] x);
      logic [SUM_W-1:0] s;
      s = SUM_W'(a) + SUM_W'(x);
      return (s > SUM_W'(COUNT_MAX)) ? COUNT_MAX : s[C-1:0];
   endfunction

   assign req_take  = (state_ff == ST_IDLE) && req_valid;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_cw_window   = rsp_window_ff;
   assign rsp_cw_exponent = rsp_exp_ff;
   assign rsp_heard_prob  = rsp_prob_ff;

   assign hsum     = DEN_W'(hr_acc_ff) + DEN_W'(hc_acc_ff);
   assign osum     = DEN_W'(or_acc_ff) + DEN_W'(ot_acc_ff);
   assign h_enough = CMP_W'(hsum) >= CMP_W'(min_samples_ff);
   assign o_enough = CMP_W'(osum) >= CMP_W'(min_samples_ff);

   // Divider load: dividend is num * 2^P + den / 2.
   always_comb begin
      if (state_ff == ST_OCHK) begin
         ld_num = DEN_W'(or_acc_ff);
         ld_den = osum;
      end else begin
         ld_num = DEN_W'(hr_acc_ff);
         ld_den = hsum;
      end
      d_full = (D_W'(ld_num) << P) + D_W'(ld_den >> 1);
   end

   // One restoring division step; the quotient shifts in behind the dividend bits.
   assign trial = {rem_ff, dlo_ff[P]};
   assign ge    = trial >= {1'b0, den_ff};
   assign q_raw = {dlo_ff[P-1:0], ge};
   assign q_sat = den_zero_ff ? '0 : (q_raw[P] ? '1 : q_raw[P-1:0]);

   assign err_c = (E_W'(heard_ff) << 1) - E_W'(target_fail_ff) - E_W'(q_sat);

   assign term = (mpe_ff[MUL_BITS-1] ? TERM_W'(gain_prop_ff) : '0)
               + (mpi_ff[MUL_BITS-1] ? TERM_W'(gain_int_ff) : '0);
   assign acc_shl = acc_ff << 1;

   always_comb begin
      win_s = $signed(acc_ff) >>> SHIFT;
      if (win_s < $signed(ACC_W'(MIN_CW))) begin
         win_c = WIN_W'(MIN_CW);
      end else if (win_s >= $signed(ACC_W'(MAX_CW))) begin
         win_c = WIN_W'(MAX_CW);
      end else begin
         win_c = win_s[WIN_W-1:0];
      end
      exp_c = MIN_EXP;
      for (int i = 0; i < EXP_EDGE_N; i++) begin
         if (win_c >= EXP_EDGE[i]) begin
            exp_c = exp_c + 4'd1;
         end
      end
   end

   assign ni = {integral_ff[INTEG_W-1], integral_ff}
             + {{(INTEG_W + 1 - E_W){err_ff[E_W-1]}}, err_ff};
   assign prob_wide = 32'(heard_ff);

   always_comb begin
      state_in      = state_ff;
      integral_in   = integral_ff;
      hr_acc_in     = hr_acc_ff;
      hc_acc_in     = hc_acc_ff;
      or_acc_in     = or_acc_ff;
      ot_acc_in     = ot_acc_ff;
      rem_in        = rem_ff;
      den_in        = den_ff;
      dlo_in        = dlo_ff;
      den_zero_in   = den_zero_ff;
      cnt_in        = cnt_ff;
      heard_in      = heard_ff;
      err_in        = err_ff;
      mpe_in        = mpe_ff;
      mpi_in        = mpi_ff;
      acc_in        = acc_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_window_in = rsp_window_ff;
      rsp_exp_in    = rsp_exp_ff;
      rsp_prob_in   = rsp_prob_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               hr_acc_in = sat_add(hr_acc_ff, req_heard_retry);
               hc_acc_in = sat_add(hc_acc_ff, req_heard_clean);
               or_acc_in = sat_add(or_acc_ff, req_own_retry);
               ot_acc_in = sat_add(ot_acc_ff, req_own_tx);
               state_in  = ST_HCHK;
            end
         end
         ST_HCHK, ST_OCHK: begin
            if ((state_ff == ST_HCHK) ? h_enough : o_enough) begin
               rem_in      = DEN_W'(d_full[D_W-1:P+1]);
               dlo_in      = d_full[P:0];
               den_in      = ld_den;
               den_zero_in = (ld_den == '0);
               cnt_in      = CNT_W'(P);
               if (state_ff == ST_HCHK) begin
                  hr_acc_in = '0;
                  hc_acc_in = '0;
                  state_in  = ST_HDIV;
               end else begin
                  or_acc_in = '0;
                  ot_acc_in = '0;
                  state_in  = ST_ODIV;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_HDIV, ST_ODIV: begin
            rem_in = ge ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
            dlo_in = q_raw;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               if (state_ff == ST_HDIV) begin
                  heard_in = q_sat;
                  state_in = ST_OCHK;
               end else begin
                  err_in   = err_c;
                  mpe_in   = {{(MUL_BITS - E_W){err_c[E_W-1]}}, err_c};
                  mpi_in   = integral_ff;
                  acc_in   = '0;
                  cnt_in   = CNT_W'(MUL_BITS - 1);
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            // MSB first; the sign bit of each multiplier carries negative weight.
            if (cnt_ff == CNT_W'(MUL_BITS - 1)) begin
               acc_in = acc_shl - ACC_W'(term);
            end else begin
               acc_in = acc_shl + ACC_W'(term);
            end
            mpe_in = mpe_ff << 1;
            mpi_in = mpi_ff << 1;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            acc_in   = acc_ff + HALF;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               if (ni[INTEG_W] != ni[INTEG_W-1]) begin
                  integral_in = ni[INTEG_W] ? {1'b1, {(INTEG_W - 1){1'b0}}}
                                            : {1'b0, {(INTEG_W - 1){1'b1}}};
               end else begin
                  integral_in = ni[INTEG_W-1:0];
               end
               rsp_valid_in  = 1'b1;
               rsp_window_in = win_c;
               rsp_exp_in    = exp_c;
               rsp_prob_in   = prob_wide[FIELD_W-1:0];
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_wr_en && (csr_addr == CSR_INTEG_START)) begin
         integral_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         min_samples_ff <= RST_MIN_SAMPLES;
         gain_prop_ff   <= RST_GAIN_PROP;
         gain_int_ff    <= RST_GAIN_INT;
         target_fail_ff <= RST_TARGET_FAIL;
         integral_ff    <= RST_INTEG_START;
         hr_acc_ff      <= '0;
         hc_acc_ff      <= '0;
         or_acc_ff      <= '0;
         ot_acc_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         integral_ff  <= integral_in;
         hr_acc_ff    <= hr_acc_in;
         hc_acc_ff    <= hc_acc_in;
         or_acc_ff    <= or_acc_in;
         ot_acc_ff    <= ot_acc_in;
         if (csr_wr_en) begin
            case (csr_addr)
               CSR_MIN_SAMPLES: min_samples_ff <= csr_wdata[FIELD_W-1:0];
               CSR_GAIN_PROP:   gain_prop_ff   <= csr_wdata[GAIN_W-1:0];
               CSR_GAIN_INT:    gain_int_ff    <= csr_wdata[GAIN_W-1:0];
               CSR_TARGET_FAIL: target_fail_ff <= csr_wdata[FIELD_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff        <= rem_in;
      den_ff        <= den_in;
      dlo_ff        <= dlo_in;
      den_zero_ff   <= den_zero_in;
      cnt_ff        <= cnt_in;
      heard_ff      <= heard_in;
      err_ff        <= err_in;
      mpe_ff        <= mpe_in;
      mpi_ff        <= mpi_in;
      acc_ff        <= acc_in;
      rsp_window_ff <= rsp_window_in;
      rsp_exp_ff    <= rsp_exp_in;
      rsp_prob_ff   <= rsp_prob_in;
   end

`ifndef SYNTHESIS
   // A new response only ever follows the final sequencer step.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("response raised outside the final step");

   // The overheard accumulators were cleared before the own ratio is divided.
   a_heard_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ODIV) |-> (hr_acc_ff == '0) && (hc_acc_ff == '0))
      else $error("overheard counts left during own division");

   // The integral moves only on a PI update or a start value write.
   a_integral_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_DONE) && !(csr_wr_en && (csr_addr == CSR_INTEG_START))
      |=> $stable(integral_ff))
      else $error("integral changed outside an update");

   // The multiplier runs its full bit count before rounding.
   a_mul_runs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) && (cnt_ff != '0) |=> (state_ff == ST_MUL))
      else $error("multiplier left early");

   // Every delivered window lies in the clamp range.
   a_window_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_window_ff >= WIN_W'(MIN_CW)) && (rsp_window_ff <= WIN_W'(MAX_CW)))
      else $error("window out of range");
`endif

endmodule
